// ===== hdl/ahp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package ahp_pkg;

   // default width of stream, file and index counters
   localparam int COUNT_BITS_DEF = 32;

   // property ids
   localparam logic [7:0] ID_END     = 8'h00;
   localparam logic [7:0] ID_HEADER  = 8'h01;
   localparam logic [7:0] ID_MAIN    = 8'h04;
   localparam logic [7:0] ID_FILES   = 8'h05;
   localparam logic [7:0] ID_PACK    = 8'h06;
   localparam logic [7:0] ID_UNPACK  = 8'h07;
   localparam logic [7:0] ID_SUBSTR  = 8'h08;
   localparam logic [7:0] ID_SIZE    = 8'h09;
   localparam logic [7:0] ID_CRC     = 8'h0A;
   localparam logic [7:0] ID_NAME    = 8'h11;
   localparam logic [7:0] ID_ENCODED = 8'h17;

   localparam logic [63:0] DATA_BASE   = 64'd32;
   localparam logic [15:0] ASCII_LIMIT = 16'd128;
   localparam logic [7:0]  SUBST_CHAR  = 8'h3F;
   localparam logic [7:0]  MASK_REST   = 8'h80;

   // event kinds
   localparam logic [2:0] EV_PACK_POS  = 3'd0;
   localparam logic [2:0] EV_STRM_CNT  = 3'd1;
   localparam logic [2:0] EV_PACK_SIZE = 3'd2;
   localparam logic [2:0] EV_FILE_CNT  = 3'd3;
   localparam logic [2:0] EV_NAME_CHAR = 3'd4;
   localparam logic [2:0] EV_NAME_END  = 3'd5;
   localparam logic [2:0] EV_DONE      = 3'd6;
   localparam logic [2:0] EV_ERROR     = 3'd7;

   // error codes
   localparam logic [63:0] ERR_ENCODED = 64'd0;
   localparam logic [63:0] ERR_STRUCT  = 64'd1;

   // number decoder state
   typedef struct packed {
      logic [63:0] value;
      logic [7:0]  mask;
      logic [3:0]  pos;
   } varint_state_type;

endpackage
`default_nettype wire

// ===== hdl/ahp_varint.sv =====
`timescale 1ns / 1ps
`default_nettype none
module ahp_varint import ahp_pkg::*; (
   input  wire logic [7:0]       data_byte,
   input  wire varint_state_type cur,
   output varint_state_type      nxt,
   output logic                  done
);

   logic [3:0] lead;
   logic [7:0] low_mask;
   logic [2:0] slot;

   // count leading ones of a first byte
   always_comb begin
      lead = 4'd8;
      for (int k = 7; k >= 0; k--) begin
         if (!data_byte[k] && lead == 4'd8) begin
            lead = 4'(7 - k);
         end
      end
   end

   assign low_mask = 8'h7F >> lead;
   assign slot     = 3'(cur.pos - 4'd1);

   // first byte or extra little-endian byte
   always_comb begin
      nxt  = cur;
      done = 1'b0;
      if (cur.pos == 4'd0) begin
         nxt.value = (lead == 4'd8) ? 64'd0
                   : (64'(data_byte & low_mask) << {lead[2:0], 3'b000});
         if (lead == 4'd0) begin
            done = 1'b1;
         end else begin
            nxt.mask = 8'(16'hFF00 >> lead);
            nxt.pos  = 4'd1;
         end
      end else begin
         nxt.value = cur.value | (64'(data_byte) << {slot, 3'b000});
         nxt.mask  = {cur.mask[6:0], 1'b0};
         nxt.pos   = cur.pos + 4'd1;
         if (nxt.mask == 8'd0) begin
            nxt.pos  = 4'd0;
            nxt.mask = MASK_REST;
            done     = 1'b1;
         end
      end
   end

endmodule
`default_nettype wire

// ===== hdl/archive_header_parser_top.sv =====
// a result beat is registered and appears in the cycle after the byte that causes it
// throughput: one header byte per cycle while the input is not stalled, set by the combinational phase update
// the byte is taken whenever the result register is empty or being drained
// reset clears the phase, counters and result valid; payload registers are not reset
`timescale 1ns / 1ps
`default_nettype none
module archive_header_parser_top import ahp_pkg::*; #(
   parameter int COUNT_BITS = COUNT_BITS_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic        req_frame_start,
   input  wire logic [7:0]  req_data_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [2:0]       rsp_event_kind,
   output logic [63:0]      rsp_event_value,
   output logic [31:0]      rsp_event_index
);

   localparam logic [4:0] PH_HDR_ID = 5'd0, PH_MAIN_ID = 5'd1, PH_MAIN_SIZE = 5'd2,
      PH_MAIN_SKIP = 5'd3, PH_STRM_ID = 5'd4, PH_STRM_SIZE = 5'd5, PH_STRM_SKIP = 5'd6,
      PH_PACK_POS = 5'd7, PH_PACK_NUM = 5'd8, PH_PACK_ID = 5'd9, PH_PACK_SIZE = 5'd10,
      PH_PACK_ID2 = 5'd11, PH_CRC_ALL = 5'd12, PH_CRC_BITS = 5'd13, PH_CRC_SKIP = 5'd14,
      PH_PACK_END = 5'd15, PH_LIST_ID = 5'd16, PH_LIST_SIZE = 5'd17, PH_LIST_SKIP = 5'd18,
      PH_FILE_NUM = 5'd19, PH_FILE_ID = 5'd20, PH_FILE_SIZE = 5'd21, PH_FILE_SKIP = 5'd22,
      PH_NAME_EXT = 5'd23, PH_NAME_DATA = 5'd24, PH_IDLE = 5'd25;

   typedef logic [COUNT_BITS-1:0] count_type;

   logic [4:0]       phase_ff, phase_in, ph;
   logic [7:0]       section_ff, section_in, sec;
   varint_state_type vint_ff, vint_in, vcur, vnxt;
   logic             vdone;
   logic [63:0]      skip_ff, skip_in, skp, skip_dec;
   logic             skip_last;
   logic [63:0]      packpos_ff, packpos_in, ppos;
   count_type        strm_ff, strm_in, scnt;
   count_type        item_ff, item_in, itm;
   count_type        defd_ff, defd_in, dfd;
   count_type        files_ff, files_in, fcnt;
   logic [31:0]      namelen_ff, namelen_in, nlen;
   logic [8:0]       hold_ff, hold_in, hld;

   logic             emit;
   logic [2:0]       ekind;
   logic [63:0]      evalue;
   count_type        eindex;
   count_type        left, take;
   logic [7:0]       top_mask;
   logic [3:0]       ones;
   logic [15:0]      unit;

   logic             rsp_valid_ff, rsp_valid_in;
   logic [2:0]       kind_ff;
   logic [63:0]      value_ff;
   logic [31:0]      index_ff;
   logic             accept;

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;

   // state as seen by this byte, frame start restarts the parser
   always_comb begin
      if (req_frame_start) begin
         ph   = PH_HDR_ID;
         sec  = 8'd0;
         vcur = '{value: 64'd0, mask: MASK_REST, pos: 4'd0};
         skp  = 64'd0;
         ppos = 64'd0;
         scnt = '0;
         itm  = '0;
         dfd  = '0;
         fcnt = '0;
         nlen = 32'd0;
         hld  = 9'd0;
      end else begin
         ph   = phase_ff;
         sec  = section_ff;
         vcur = vint_ff;
         skp  = skip_ff;
         ppos = packpos_ff;
         scnt = strm_ff;
         itm  = item_ff;
         dfd  = defd_ff;
         fcnt = files_ff;
         nlen = namelen_ff;
         hld  = hold_ff;
      end
   end

   ahp_varint u_varint (
      .data_byte (req_data_byte),
      .cur       (vcur),
      .nxt       (vnxt),
      .done      (vdone)
   );

   // skip counter step
   assign skip_dec  = (skp != 64'd0) ? skp - 64'd1 : 64'd0;
   assign skip_last = (skip_dec == 64'd0);

   // digest bit vector: msb first, only the bits still owed
   assign left     = scnt - itm;
   assign take     = (left < count_type'(8)) ? left : count_type'(8);
   assign top_mask = 8'(16'hFF00 >> take[3:0]);
   always_comb begin
      ones = 4'd0;
      for (int k = 0; k < 8; k++) begin
         ones = ones + 4'(req_data_byte[k] & top_mask[k]);
      end
   end

   assign unit = {req_data_byte, hld[7:0]};

   // phase update
   always_comb begin
      phase_in   = ph;
      section_in = sec;
      vint_in    = vcur;
      skip_in    = skp;
      packpos_in = ppos;
      strm_in    = scnt;
      item_in    = itm;
      defd_in    = dfd;
      files_in   = fcnt;
      namelen_in = nlen;
      hold_in    = hld;
      emit       = 1'b0;
      ekind      = EV_ERROR;
      evalue     = 64'd0;
      eindex     = '0;
      case (ph)
         PH_HDR_ID: begin
            phase_in = PH_IDLE;
            if (req_data_byte == ID_ENCODED) begin
               emit = 1'b1;
               evalue = ERR_ENCODED;
            end else if (req_data_byte != ID_HEADER) begin
               emit = 1'b1;
               evalue = ERR_STRUCT;
            end else begin
               phase_in = PH_MAIN_ID;
            end
         end
         PH_MAIN_ID: begin
            section_in = req_data_byte;
            if (req_data_byte == ID_END) begin
               phase_in = PH_IDLE;
               emit = 1'b1;
               ekind = EV_DONE;
               evalue = ppos + DATA_BASE;
            end else if (req_data_byte == ID_MAIN) begin
               phase_in = PH_STRM_ID;
            end else if (req_data_byte == ID_FILES) begin
               phase_in = PH_FILE_NUM;
            end else begin
               phase_in = PH_MAIN_SIZE;
            end
         end
         PH_MAIN_SIZE, PH_STRM_SIZE, PH_LIST_SIZE, PH_FILE_SIZE: begin
            vint_in = vnxt;
            if (vdone) begin
               skip_in = vnxt.value;
               if (vnxt.value == 64'd0) begin
                  phase_in = (ph == PH_MAIN_SIZE) ? PH_MAIN_ID
                           : (ph == PH_STRM_SIZE) ? PH_STRM_ID
                           : (ph == PH_LIST_SIZE) ? PH_LIST_ID : PH_FILE_ID;
               end else begin
                  phase_in = (ph == PH_MAIN_SIZE) ? PH_MAIN_SKIP
                           : (ph == PH_STRM_SIZE) ? PH_STRM_SKIP
                           : (ph == PH_LIST_SIZE) ? PH_LIST_SKIP
                           : (sec == ID_NAME) ? PH_NAME_EXT : PH_FILE_SKIP;
               end
            end
         end
         PH_MAIN_SKIP, PH_STRM_SKIP, PH_LIST_SKIP, PH_FILE_SKIP, PH_CRC_SKIP: begin
            skip_in = skip_dec;
            if (skip_last) begin
               phase_in = (ph == PH_MAIN_SKIP) ? PH_MAIN_ID
                        : (ph == PH_STRM_SKIP) ? PH_STRM_ID
                        : (ph == PH_LIST_SKIP) ? PH_LIST_ID
                        : (ph == PH_FILE_SKIP) ? PH_FILE_ID : PH_PACK_END;
            end
         end
         PH_STRM_ID: begin
            section_in = req_data_byte;
            if (req_data_byte == ID_END) begin
               phase_in = PH_MAIN_ID;
            end else if (req_data_byte == ID_PACK) begin
               phase_in = PH_PACK_POS;
            end else if (req_data_byte == ID_UNPACK || req_data_byte == ID_SUBSTR) begin
               phase_in = PH_LIST_ID;
            end else begin
               phase_in = PH_STRM_SIZE;
            end
         end
         PH_PACK_POS: begin
            vint_in = vnxt;
            if (vdone) begin
               packpos_in = vnxt.value;
               phase_in = PH_PACK_NUM;
               emit = 1'b1;
               ekind = EV_PACK_POS;
               evalue = vnxt.value;
            end
         end
         PH_PACK_NUM: begin
            vint_in = vnxt;
            if (vdone) begin
               strm_in = vnxt.value[COUNT_BITS-1:0];
               phase_in = PH_PACK_ID;
               emit = 1'b1;
               ekind = EV_STRM_CNT;
               evalue = 64'(vnxt.value[COUNT_BITS-1:0]);
            end
         end
         PH_PACK_ID, PH_PACK_ID2: begin
            if (req_data_byte == ID_SIZE && ph == PH_PACK_ID) begin
               item_in = '0;
               phase_in = (scnt == '0) ? PH_PACK_ID2 : PH_PACK_SIZE;
            end else if (req_data_byte == ID_CRC) begin
               item_in = '0;
               defd_in = '0;
               phase_in = PH_CRC_ALL;
            end else if (req_data_byte == ID_END) begin
               phase_in = PH_STRM_ID;
            end else begin
               phase_in = PH_IDLE;
               emit = 1'b1;
               evalue = ERR_STRUCT;
            end
         end
         PH_PACK_SIZE: begin
            vint_in = vnxt;
            if (vdone) begin
               item_in = itm + count_type'(1);
               if (item_in >= scnt) begin
                  phase_in = PH_PACK_ID2;
               end
               emit = 1'b1;
               ekind = EV_PACK_SIZE;
               evalue = vnxt.value;
               eindex = itm;
            end
         end
         PH_CRC_ALL: begin
            if (req_data_byte != 8'd0 || scnt == '0) begin
               defd_in = (req_data_byte != 8'd0) ? scnt : dfd;
               skip_in = {62'(defd_in), 2'b00};
               phase_in = (defd_in == '0) ? PH_PACK_END : PH_CRC_SKIP;
            end else begin
               phase_in = PH_CRC_BITS;
            end
         end
         PH_CRC_BITS: begin
            defd_in = dfd + count_type'(ones);
            item_in = itm + take;
            if (item_in >= scnt) begin
               skip_in = {62'(defd_in), 2'b00};
               phase_in = (defd_in == '0) ? PH_PACK_END : PH_CRC_SKIP;
            end
         end
         PH_PACK_END: begin
            if (req_data_byte == ID_END) begin
               phase_in = PH_STRM_ID;
            end else begin
               phase_in = PH_IDLE;
               emit = 1'b1;
               evalue = ERR_STRUCT;
            end
         end
         PH_LIST_ID: begin
            phase_in = (req_data_byte == ID_END) ? PH_STRM_ID : PH_LIST_SIZE;
         end
         PH_FILE_NUM: begin
            vint_in = vnxt;
            if (vdone) begin
               files_in = vnxt.value[COUNT_BITS-1:0];
               phase_in = PH_FILE_ID;
               emit = 1'b1;
               ekind = EV_FILE_CNT;
               evalue = 64'(vnxt.value[COUNT_BITS-1:0]);
            end
         end
         PH_FILE_ID: begin
            section_in = req_data_byte;
            phase_in = (req_data_byte == ID_END) ? PH_MAIN_ID : PH_FILE_SIZE;
         end
         PH_NAME_EXT: begin
            skip_in = skip_dec;
            item_in = '0;
            namelen_in = 32'd0;
            hold_in = 9'd0;
            if (skip_last) begin
               phase_in = PH_FILE_ID;
            end else begin
               phase_in = (req_data_byte != 8'd0) ? PH_FILE_SKIP : PH_NAME_DATA;
            end
         end
         PH_NAME_DATA: begin
            skip_in = skip_dec;
            if (itm < fcnt) begin
               if (!hld[8]) begin
                  hold_in = {1'b1, req_data_byte};
               end else begin
                  hold_in = 9'd0;
                  emit = 1'b1;
                  eindex = itm;
                  if (unit == 16'd0) begin
                     ekind = EV_NAME_END;
                     evalue = 64'(nlen);
                     item_in = itm + count_type'(1);
                     namelen_in = 32'd0;
                  end else begin
                     ekind = EV_NAME_CHAR;
                     evalue = (unit < ASCII_LIMIT) ? 64'(unit) : 64'(SUBST_CHAR);
                     namelen_in = nlen + 32'd1;
                  end
               end
            end
            if (skip_last) begin
               hold_in = 9'd0;
               phase_in = PH_FILE_ID;
            end
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase
   end

   // parser state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_HDR_ID;
         section_ff <= 8'd0;
         vint_ff    <= '{value: 64'd0, mask: MASK_REST, pos: 4'd0};
         skip_ff    <= 64'd0;
         packpos_ff <= 64'd0;
         strm_ff    <= '0;
         item_ff    <= '0;
         defd_ff    <= '0;
         files_ff   <= '0;
         namelen_ff <= 32'd0;
         hold_ff    <= 9'd0;
      end else if (accept) begin
         phase_ff   <= phase_in;
         section_ff <= section_in;
         vint_ff    <= vint_in;
         skip_ff    <= skip_in;
         packpos_ff <= packpos_in;
         strm_ff    <= strm_in;
         item_ff    <= item_in;
         defd_ff    <= defd_in;
         files_ff   <= files_in;
         namelen_ff <= namelen_in;
         hold_ff    <= hold_in;
      end
   end

   // result register
   assign rsp_valid_in = accept ? emit : (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && emit) begin
         kind_ff  <= ekind;
         value_ff <= evalue;
         index_ff <= 32'(eindex);
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_event_kind  = kind_ff;
   assign rsp_event_value = value_ff;
   assign rsp_event_index = index_ff;

   // checks
   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid_ff)
      else $error("input stalled with empty result register");

   a_idle_silent: assert property (@(posedge clock) disable iff (reset)
      accept && !req_frame_start && phase_ff == PH_IDLE |=> !rsp_valid_ff)
      else $error("result beat after done or error");

   a_error_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && kind_ff == EV_ERROR |-> value_ff <= ERR_STRUCT)
      else $error("bad error code");

   a_varint_rest: assert property (@(posedge clock) disable iff (reset)
      vint_ff.pos == 4'd0 |-> vint_ff.mask == MASK_REST)
      else $error("number decoder not at rest");

endmodule
`default_nettype wire

// ===== tb/sv/tb_archive_header_parser_top.sv =====
`timescale 1ns / 1ps
module tb_archive_header_parser_top;
   import ahp_pkg::*;

   typedef struct {
      bit       frame;
      bit [7:0] data;
   } hdr_beat_t;

   typedef struct {
      bit [2:0]  kind;
      bit [63:0] value;
      bit [31:0] index;
   } parse_event_t;

   typedef enum int {
      P_HDR_ID, P_MAIN_ID, P_MAIN_SIZE, P_MAIN_SKIP,
      P_STRM_ID, P_STRM_SIZE, P_STRM_SKIP,
      P_PACK_POS, P_PACK_NUM, P_PACK_ID, P_PACK_SIZE, P_PACK_ID2,
      P_CRC_ALL, P_CRC_BITS, P_CRC_SKIP, P_PACK_END,
      P_LIST_ID, P_LIST_SIZE, P_LIST_SKIP,
      P_FILE_NUM, P_FILE_ID, P_FILE_SIZE, P_FILE_SKIP,
      P_NAME_EXT, P_NAME_DATA, P_IDLE
   } parse_phase_t;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic        req_frame_start;
   logic [7:0]  req_data_byte;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [2:0]  rsp_event_kind;
   logic [63:0] rsp_event_value;
   logic [31:0] rsp_event_index;

   hdr_beat_t    header_bytes_q[$];
   parse_event_t expected_events_q[$];
   int           error_count = 0;
   bit           req_fire = 0;
   int           burst_left = 0;
   int           gap_left = 0;
   int           cycle_count = 0;

   // parser state mirror
   parse_phase_t phase;
   bit [7:0]     sec_id;
   bit [63:0]    num_value;
   bit [7:0]     num_mask;
   bit [3:0]     num_pos;
   bit [63:0]    skip_left;
   bit [63:0]    pack_pos;
   bit [31:0]    strm_cnt;
   bit [31:0]    item_idx;
   bit [31:0]    def_bits;
   bit [31:0]    file_cnt;
   bit [31:0]    name_len;
   bit [8:0]     lo_hold;

   archive_header_parser_top u_top (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_frame_start(req_frame_start),
      .req_data_byte(req_data_byte),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_event_kind(rsp_event_kind),
      .rsp_event_value(rsp_event_value),
      .rsp_event_index(rsp_event_index)
   );

   // clock
   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   // reset and timeout
   initial begin
      reset = 1'b1;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
   end

   initial begin
      #(3000000);
      $display("CHECK FAILED");
      $finish;
   end

   // parser model
   task automatic clear_state();
      phase = P_HDR_ID;
      sec_id = 0;
      num_value = 0;
      num_mask = MASK_REST;
      num_pos = 0;
      skip_left = 0;
      pack_pos = 0;
      strm_cnt = 0;
      item_idx = 0;
      def_bits = 0;
      file_cnt = 0;
      name_len = 0;
      lo_hold = 0;
   endtask

   function automatic bit number_byte(bit [7:0] b);
      int n;
      n = 0;
      if (num_pos == 0) begin
         while (n < 8 && b[7 - n]) n++;
         num_value = (n < 8) ? (64'(b & (8'h7F >> n)) << (8 * n)) : 64'd0;
         if (n == 0) return 1'b1;
         num_mask = 8'((16'hFF00 >> n) & 16'hFF);
         num_pos = 1;
         return 1'b0;
      end
      num_value |= 64'(b) << (8 * ((num_pos - 1) & 7));
      num_mask = num_mask << 1;
      num_pos = num_pos + 1;
      if (num_mask == 0) begin
         num_pos = 0;
         num_mask = MASK_REST;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic bit skip_done();
      if (skip_left != 0) skip_left--;
      return skip_left == 0;
   endfunction

   function automatic void begin_skip(parse_phase_t skip_ph, parse_phase_t back_ph);
      skip_left = num_value;
      phase = (skip_left == 0) ? back_ph : skip_ph;
   endfunction

   function automatic void digests_done();
      skip_left = 64'(def_bits) * 4;
      phase = (skip_left == 0) ? P_PACK_END : P_CRC_SKIP;
   endfunction

   function automatic void add_event(bit [2:0] k, bit [63:0] v, bit [31:0] i);
      parse_event_t e;
      e.kind = k;
      e.value = v;
      e.index = i;
      expected_events_q.push_back(e);
   endfunction

   task automatic parse_byte(bit frame, bit [7:0] b);
      bit [31:0] idx;
      bit [31:0] left;
      bit [15:0] unit;
      bit        last;
      if (frame) clear_state();
      case (phase)
         P_HDR_ID: begin
            phase = P_IDLE;
            if (b == ID_ENCODED) add_event(EV_ERROR, ERR_ENCODED, 0);
            else if (b != ID_HEADER) add_event(EV_ERROR, ERR_STRUCT, 0);
            else phase = P_MAIN_ID;
         end
         P_MAIN_ID: begin
            sec_id = b;
            if (b == ID_END) begin
               phase = P_IDLE;
               add_event(EV_DONE, pack_pos + DATA_BASE, 0);
            end else if (b == ID_MAIN) phase = P_STRM_ID;
            else if (b == ID_FILES) phase = P_FILE_NUM;
            else phase = P_MAIN_SIZE;
         end
         P_MAIN_SIZE: if (number_byte(b)) begin_skip(P_MAIN_SKIP, P_MAIN_ID);
         P_MAIN_SKIP: if (skip_done()) phase = P_MAIN_ID;
         P_STRM_ID: begin
            sec_id = b;
            if (b == ID_END) phase = P_MAIN_ID;
            else if (b == ID_PACK) phase = P_PACK_POS;
            else if (b == ID_UNPACK || b == ID_SUBSTR) phase = P_LIST_ID;
            else phase = P_STRM_SIZE;
         end
         P_STRM_SIZE: if (number_byte(b)) begin_skip(P_STRM_SKIP, P_STRM_ID);
         P_STRM_SKIP: if (skip_done()) phase = P_STRM_ID;
         P_PACK_POS: if (number_byte(b)) begin
            pack_pos = num_value;
            phase = P_PACK_NUM;
            add_event(EV_PACK_POS, pack_pos, 0);
         end
         P_PACK_NUM: if (number_byte(b)) begin
            strm_cnt = num_value[31:0];
            phase = P_PACK_ID;
            add_event(EV_STRM_CNT, 64'(strm_cnt), 0);
         end
         P_PACK_ID, P_PACK_ID2: begin
            if (b == ID_SIZE && phase == P_PACK_ID) begin
               item_idx = 0;
               phase = (strm_cnt == 0) ? P_PACK_ID2 : P_PACK_SIZE;
            end else if (b == ID_CRC) begin
               item_idx = 0;
               def_bits = 0;
               phase = P_CRC_ALL;
            end else if (b == ID_END) phase = P_STRM_ID;
            else begin
               phase = P_IDLE;
               add_event(EV_ERROR, ERR_STRUCT, 0);
            end
         end
         P_PACK_SIZE: begin
            idx = item_idx;
            if (number_byte(b)) begin
               item_idx++;
               if (item_idx >= strm_cnt) phase = P_PACK_ID2;
               add_event(EV_PACK_SIZE, num_value, idx);
            end
         end
         P_CRC_ALL: begin
            if (b != 0) begin
               def_bits = strm_cnt;
               digests_done();
            end else if (strm_cnt == 0) digests_done();
            else phase = P_CRC_BITS;
         end
         P_CRC_BITS: begin
            left = strm_cnt - item_idx;
            if (left > 8) left = 8;
            for (int k = 0; k < left; k++) if (b[7 - k]) def_bits++;
            item_idx += left;
            if (item_idx >= strm_cnt) digests_done();
         end
         P_CRC_SKIP: if (skip_done()) phase = P_PACK_END;
         P_PACK_END: begin
            if (b == ID_END) phase = P_STRM_ID;
            else begin
               phase = P_IDLE;
               add_event(EV_ERROR, ERR_STRUCT, 0);
            end
         end
         P_LIST_ID: phase = (b == ID_END) ? P_STRM_ID : P_LIST_SIZE;
         P_LIST_SIZE: if (number_byte(b)) begin_skip(P_LIST_SKIP, P_LIST_ID);
         P_LIST_SKIP: if (skip_done()) phase = P_LIST_ID;
         P_FILE_NUM: if (number_byte(b)) begin
            file_cnt = num_value[31:0];
            phase = P_FILE_ID;
            add_event(EV_FILE_CNT, 64'(file_cnt), 0);
         end
         P_FILE_ID: begin
            sec_id = b;
            phase = (b == ID_END) ? P_MAIN_ID : P_FILE_SIZE;
         end
         P_FILE_SIZE: if (number_byte(b))
            begin_skip((sec_id == ID_NAME) ? P_NAME_EXT : P_FILE_SKIP, P_FILE_ID);
         P_FILE_SKIP: if (skip_done()) phase = P_FILE_ID;
         P_NAME_EXT: begin
            last = skip_done();
            item_idx = 0;
            name_len = 0;
            lo_hold = 0;
            if (last) phase = P_FILE_ID;
            else phase = (b != 0) ? P_FILE_SKIP : P_NAME_DATA;
         end
         P_NAME_DATA: begin
            last = skip_done();
            if (item_idx < file_cnt) begin
               if (!lo_hold[8]) lo_hold = {1'b1, b};
               else begin
                  unit = {b, lo_hold[7:0]};
                  lo_hold = 0;
                  if (unit == 0) begin
                     add_event(EV_NAME_END, 64'(name_len), item_idx);
                     item_idx++;
                     name_len = 0;
                  end else begin
                     add_event(EV_NAME_CHAR,
                        (unit < ASCII_LIMIT) ? 64'(unit) : 64'(SUBST_CHAR), item_idx);
                     name_len++;
                  end
               end
            end
            if (last) begin
               lo_hold = 0;
               phase = P_FILE_ID;
            end
         end
         default: phase = P_IDLE;
      endcase
   endtask

   // stimulus builders
   task automatic put(bit frame, bit [7:0] b);
      hdr_beat_t t;
      t.frame = frame;
      t.data = b;
      header_bytes_q.push_back(t);
   endtask

   task automatic put_number(bit [63:0] v);
      int n;
      int lo;
      lo = 8;
      for (int k = 0; k < 8; k++)
         if (lo == 8 && (v >> (7 * k + 7)) == 0) lo = k;
      n = (lo < 8 && $urandom_range(0, 3) == 0) ? $urandom_range(lo, 8) : lo;
      if (n == 8) put(0, 8'hFF);
      else put(0, 8'((16'hFF00 >> n) & 16'hFF) | (8'(v >> (8 * n)) & (8'h7F >> n)));
      for (int k = 0; k < n; k++) put(0, 8'(v >> (8 * k)));
   endtask

   function automatic bit [63:0] rand_wide();
      case ($urandom_range(0, 5))
         0: return {$urandom, $urandom};
         1: return 64'hFFFF_FFFF_FFFF_FFFF - $urandom_range(0, 40);
         2: return 64'(1) << $urandom_range(0, 63);
         default: return $urandom_range(0, 300);
      endcase
   endfunction

   function automatic bit [7:0] rand_id_except(bit [7:0] a, bit [7:0] b, bit [7:0] c);
      bit [7:0] id;
      id = 8'($urandom_range(0, 255));
      while (id == a || id == b || id == c || id == ID_END)
         id = 8'($urandom_range(1, 255));
      return id;
   endfunction

   task automatic put_sized_prop(bit [7:0] id);
      int s;
      s = $urandom_range(0, 6);
      put(0, id);
      put_number(s);
      repeat (s) put(0, 8'($urandom));
   endtask

   task automatic put_pack_info();
      bit [63:0] cnt;
      int        c;
      int        defd;
      bit [7:0]  v;
      put(0, ID_PACK);
      put_number(rand_wide());
      cnt = ($urandom_range(0, 9) == 0) ? rand_wide() : 64'($urandom_range(0, 10));
      put_number(cnt);
      if (cnt > 20) begin
         put(0, ID_END);
         return;
      end
      c = int'(cnt);
      if ($urandom_range(0, 2) != 0) begin
         put(0, ID_SIZE);
         repeat (c) put_number(rand_wide());
      end
      if ($urandom_range(0, 1) != 0) begin
         put(0, ID_CRC);
         if ($urandom_range(0, 1) != 0) begin
            put(0, 8'($urandom_range(1, 255)));
            defd = c;
         end else begin
            put(0, 8'h00);
            defd = 0;
            for (int k = 0; k < c; k += 8) begin
               v = 8'($urandom);
               put(0, v);
               for (int j = 0; j < 8 && k + j < c; j++) if (v[7 - j]) defd++;
            end
         end
         repeat (4 * defd) put(0, 8'($urandom));
      end
      // broken pack section now and then
      if ($urandom_range(0, 11) == 0) put(0, 8'($urandom));
      else put(0, ID_END);
   endtask

   task automatic put_streams();
      put(0, ID_MAIN);
      repeat ($urandom_range(0, 3)) begin
         case ($urandom_range(0, 3))
            0, 1: put_pack_info();
            2: begin
               put(0, $urandom_range(0, 1) ? ID_UNPACK : ID_SUBSTR);
               repeat ($urandom_range(0, 2)) put_sized_prop(rand_id_except(0, 0, 0));
               put(0, ID_END);
            end
            default: put_sized_prop(rand_id_except(ID_PACK, ID_UNPACK, ID_SUBSTR));
         endcase
      end
      put(0, ID_END);
   endtask

   task automatic put_names(int nf);
      bit [7:0]  nd[$];
      bit [15:0] u;
      int        ne;
      ne = nf + $urandom_range(0, 1);
      for (int f = 0; f < ne && f < 6; f++) begin
         repeat ($urandom_range(0, 5)) begin
            case ($urandom_range(0, 3))
               0: u = 16'($urandom_range(128, 65535));
               1: u = 16'($urandom_range(1, 255));
               default: u = 16'($urandom_range(1, 127));
            endcase
            nd.push_back(u[7:0]);
            nd.push_back(u[15:8]);
         end
         if ($urandom_range(0, 7) != 0) begin
            nd.push_back(8'h00);
            nd.push_back(8'h00);
         end
      end
      if ($urandom_range(0, 4) == 0) nd.push_back(8'($urandom));
      put(0, ID_NAME);
      put_number(nd.size() + 1);
      put(0, 8'h00);
      foreach (nd[k]) put(0, nd[k]);
   endtask

   task automatic put_files();
      bit [63:0] cnt;
      int        s;
      cnt = ($urandom_range(0, 7) == 0) ? rand_wide() : 64'($urandom_range(0, 5));
      put(0, ID_FILES);
      put_number(cnt);
      repeat ($urandom_range(0, 3)) begin
         case ($urandom_range(0, 5))
            0: begin
               // empty name property
               put(0, ID_NAME);
               put_number(0);
            end
            1: begin
               // external names
               s = $urandom_range(1, 5);
               put(0, ID_NAME);
               put_number(s);
               put(0, 8'($urandom_range(1, 255)));
               repeat (s - 1) put(0, 8'($urandom));
            end
            2: put_sized_prop(rand_id_except(ID_NAME, ID_NAME, ID_NAME));
            default: put_names((cnt > 6) ? 6 : int'(cnt));
         endcase
      end
      put(0, ID_END);
   endtask

   task automatic put_frame();
      int r;
      r = $urandom_range(0, 19);
      if (r == 0) put(1, ID_ENCODED);
      else if (r == 1) put(1, 8'($urandom));
      else put(1, ID_HEADER);
      repeat ($urandom_range(0, 3)) begin
         case ($urandom_range(0, 4))
            0: put_sized_prop(rand_id_except(ID_MAIN, ID_FILES, ID_FILES));
            1, 2: put_streams();
            default: put_files();
         endcase
      end
      // truncated frame, stray byte, or normal end
      r = $urandom_range(0, 14);
      if (r == 0) return;
      if (r == 1) put(0, 8'($urandom));
      put(0, ID_END);
      repeat ($urandom_range(0, 2)) put(0, 8'($urandom));
   endtask

   // directed frames, then random ones
   initial begin
      req_valid = 1'b0;
      req_frame_start = 1'b0;
      req_data_byte = 8'h00;
      rsp_stall = 1'b0;
      // encoded header, bad id, empty header
      put(1, ID_ENCODED);
      put(0, 8'h01);
      put(1, 8'hFF);
      put(1, ID_HEADER);
      put(0, ID_END);
      put(0, 8'h55);
      // widest pack position, no sizes but all-zero digest vector with zero count
      put(1, ID_HEADER);
      put(0, ID_MAIN);
      put(0, ID_PACK);
      for (int k = 0; k < 9; k++) put(0, 8'hFF);
      put(0, 8'h00);
      put(0, ID_CRC);
      put(0, 8'h00);
      put(0, ID_END);
      put(0, ID_END);
      put(0, ID_END);
      // sizes after digests is a structure error
      put(1, ID_HEADER);
      put(0, ID_MAIN);
      put(0, ID_PACK);
      put(0, 8'h00);
      put(0, 8'h00);
      put(0, ID_CRC);
      put(0, 8'h80);
      put(0, ID_SIZE);
      while (header_bytes_q.size() < 1150) put_frame();
   end

   // sender: bursts with gaps, change on the falling edge
   always @(negedge clock) begin
      hdr_beat_t t;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_fire) begin
         if (burst_left == 0 && gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (header_bytes_q.size() != 0) begin
            if (burst_left == 0) begin
               burst_left = $urandom_range(1, 40);
               gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            end
            burst_left--;
            t = header_bytes_q.pop_front();
            req_valid <= 1'b1;
            req_frame_start <= t.frame;
            req_data_byte <= t.data;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver stall pattern, with one long hold-off early on
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         cycle_count++;
         if (cycle_count >= 400 && cycle_count < 700) rsp_stall <= 1'b1;
         else case ((cycle_count / 150) % 3)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom_range(0, 9) < 4);
            default: rsp_stall <= (cycle_count % 4 == 0);
         endcase
      end
   end

   task automatic report(string what, bit [63:0] got, bit [63:0] want);
      error_count++;
      $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
   endtask

   // result check and prediction at the rising edge
   always @(posedge clock) begin
      parse_event_t e;
      if (reset) begin
         req_fire <= 1'b0;
         clear_state();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_events_q.size() == 0) begin
               report("unexpected beat kind", rsp_event_kind, 0);
            end else begin
               e = expected_events_q.pop_front();
               if (rsp_event_kind !== e.kind) report("kind", rsp_event_kind, e.kind);
               if (rsp_event_value !== e.value) report("value", rsp_event_value, e.value);
               if (rsp_event_index !== e.index) report("index", rsp_event_index, e.index);
            end
         end
         if (req_valid && !req_stall) parse_byte(req_frame_start, req_data_byte);
         req_fire <= req_valid && !req_stall;
      end
   end

   // end of run
   initial begin
      @(negedge reset);
      @(posedge clock);
      while (header_bytes_q.size() != 0 || req_valid) @(posedge clock);
      while (expected_events_q.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (error_count == 0 && expected_events_q.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
